/* rtl/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants for the RPN stack evaluator
// Token kinds, payload structs, state encoding and default sizes.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 32;

    typedef enum logic [2:0] {
        K_PUSH = 3'd0,
        K_ADD  = 3'd1,
        K_SUB  = 3'd2,
        K_MUL  = 3'd3,
        K_DIV  = 3'd4,
        K_EOL  = 3'd5,
        K_UNK  = 3'd6,
        K_RSV  = 3'd7
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] operand_value;
    } t_in;

    typedef struct packed {
        logic [63:0] printed_value;
        logic        printed_valid;
        logic        underflow;
        logic        overflow;
        logic        zero_divisor;
        logic        unknown_command;
        logic [7:0]  stack_depth;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_R,
        S_WAIT_R,
        S_RD_L,
        S_WAIT_L,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

/* rtl/rpn_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top: Reverse Polish evaluator over a memory stack
// One token per beat in, one status/result beat out per token.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  input   | in  | i_valid / o_ready   | i_data  (t_in: kind, operand_value)
//  output  | out | o_valid / i_ready   | o_data  (t_out: printed value, flags, depth)
//
// Per token: push and unknown go straight to the result beat; end of line and
// divide by a zero divisor stop after reading the right operand; add/sub read
// both operands; multiply sums four 32x32 partial products, one per cycle;
// divide is a restoring divider that yields one quotient bit per cycle.
// Reset clears the stack count and control; stack memory is not cleared and
// only entries below the count are read.
// The block holds one token at a time; a stalled output beat blocks the next
// token until taken.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  rse_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output rse_pkg::t_out o_data
);
    import rse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = VALUE_WIDTH;
    localparam int W2 = 2 * VALUE_WIDTH;
    localparam int IW = $clog2(W2 + 1);

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // stack memory: one write port, one registered read port
    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rd;
    logic         n_we;
    logic [AW-1:0] n_waddr, n_raddr;
    logic [W-1:0] n_wdata;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rd <= r_mem[n_raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_kind  r_kind, n_kind;
    logic signed [W-1:0] r_a, n_a, r_b, n_b;     // a: left, b: right
    logic r_und, n_und, r_ovf, n_ovf, r_zd, n_zd;
    logic signed [W-1:0] r_res, n_res;
    logic r_has, n_has;                             // result to push
    t_out r_out, n_out;
    logic r_ov, n_ov;

    // multiply and divide datapath regs
    logic [W-1:0]  r_ma, n_ma, r_mb, n_mb;
    logic [W2-1:0] r_acc, n_acc;
    logic [1:0]    r_mstep, n_mstep;
    logic [W2-1:0] r_num, n_num;
    logic [W:0]    r_rem, n_rem;
    logic [W2-1:0] r_q, n_q;
    logic [IW-1:0] r_i, n_i;
    logic          r_neg, n_neg;

    // clamp of the incoming 64-bit operand to W bits
    logic signed [63:0] in_val;
    logic signed [W-1:0] push_val;
    assign in_val = signed'(i_data.operand_value);
    always_comb begin
        if (in_val > 64'(signed'(VMAX))) begin
            push_val = VMAX;
        end else if (in_val < 64'(signed'(VMIN))) begin
            push_val = VMIN;
        end else begin
            push_val = W'(in_val);
        end
    end

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    // saturate a 2W magnitude with sign
    function automatic logic signed [W-1:0] from_mag(input logic ng,
                                                     input logic [W2-1:0] m);
        logic [W-1:0] hi, lo;
        hi = m[W2-1:W];
        lo = m[W-1:0];
        if (ng) begin
            if (hi != '0 || lo >= W'(VMIN)) return VMIN;
            return signed'(W'(-lo));
        end
        if (hi != '0 || lo > W'(VMAX)) return VMAX;
        return signed'(lo);
    endfunction

    logic signed [W:0] sum_w, dif_w;
    assign sum_w = {r_a[W-1], r_a} + {r_b[W-1], r_b};
    assign dif_w = {r_a[W-1], r_a} - {r_b[W-1], r_b};

    localparam int HW = (W + 1) / 2;
    logic [HW-1:0] pa, pb;
    logic [2*HW-1:0] pp;
    logic [W:0] rem_sh;
    logic [W:0] rem_sub;

    always_comb begin
        case (r_mstep)
            2'd0:    begin pa = HW'(r_ma);       pb = HW'(r_mb);       end
            2'd1:    begin pa = HW'(r_ma);       pb = HW'(r_mb >> HW); end
            2'd2:    begin pa = HW'(r_ma >> HW); pb = HW'(r_mb);       end
            default: begin pa = HW'(r_ma >> HW); pb = HW'(r_mb >> HW); end
        endcase
        pp = pa * pb;
        rem_sh  = {r_rem[W-1:0], r_num[W2-1]};
        rem_sub = rem_sh - {1'b0, r_mb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b;
        r_und <= n_und; r_ovf <= n_ovf; r_zd <= n_zd;
        r_res <= n_res; r_has <= n_has; r_out <= n_out;
        r_ma <= n_ma; r_mb <= n_mb; r_acc <= n_acc; r_mstep <= n_mstep;
        r_num <= n_num; r_rem <= n_rem; r_q <= n_q; r_i <= n_i; r_neg <= n_neg;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_kind = r_kind;
        n_a = r_a; n_b = r_b; n_und = r_und; n_ovf = r_ovf; n_zd = r_zd;
        n_res = r_res; n_has = r_has; n_out = r_out; n_ov = r_ov;
        n_ma = r_ma; n_mb = r_mb; n_acc = r_acc; n_mstep = r_mstep;
        n_num = r_num; n_rem = r_rem; n_q = r_q; n_i = r_i; n_neg = r_neg;
        n_we = 1'b0; n_waddr = AW'(r_cnt); n_wdata = r_res;
        n_raddr = AW'(r_cnt - CW'(1));
        o_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind = t_kind'(i_data.kind);
                    n_und = 1'b0; n_ovf = 1'b0; n_zd = 1'b0; n_has = 1'b0;
                    n_a = '0; n_b = '0; n_res = push_val;
                    case (t_kind'(i_data.kind))
                        K_PUSH: begin
                            n_has = 1'b1;
                            n_state = S_FIN;
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV, K_EOL: n_state = S_RD_R;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_RD_R: n_state = S_WAIT_R;       // read address issued from count
            S_WAIT_R: begin
                if (r_cnt == '0) begin
                    n_und = 1'b1;
                    n_b = '0;
                end else begin
                    n_b = signed'(r_rd);
                    n_cnt = r_cnt - CW'(1);
                end
                if (r_kind == K_EOL) begin
                    n_state = S_FIN;
                end else if (r_kind == K_DIV && (r_cnt == '0 || r_rd == '0)) begin
                    n_zd = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD_L;
                end
            end
            S_RD_L: n_state = S_WAIT_L;
            S_WAIT_L: begin
                if (r_cnt == '0) begin
                    n_und = 1'b1;
                    n_a = '0;
                end else begin
                    n_a = signed'(r_rd);
                    n_cnt = r_cnt - CW'(1);
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_has = 1'b1;
                n_neg = r_a[W-1] ^ r_b[W-1];
                n_ma = mag(r_a); n_mb = mag(r_b);
                n_acc = '0; n_mstep = '0;
                n_num = W2'(mag(r_a)) << FRAC_BITS;
                n_rem = '0; n_q = '0; n_i = IW'(W2);
                case (r_kind)
                    K_ADD: begin
                        n_res = (sum_w[W] != sum_w[W-1]) ?
                                (sum_w[W] ? VMIN : VMAX) : sum_w[W-1:0];
                        n_state = S_FIN;
                    end
                    K_SUB: begin
                        n_res = (dif_w[W] != dif_w[W-1]) ?
                                (dif_w[W] ? VMIN : VMAX) : dif_w[W-1:0];
                        n_state = S_FIN;
                    end
                    K_MUL:   n_state = S_MUL;
                    default: n_state = S_DIV;
                endcase
            end
            S_MUL: begin
                // accumulate one partial product per cycle
                case (r_mstep)
                    2'd0:    n_acc = r_acc + W2'(pp);
                    2'd1,
                    2'd2:    n_acc = r_acc + (W2'(pp) << HW);
                    default: n_acc = r_acc + (W2'(pp) << (2 * HW));
                endcase
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd3) begin
                    n_res = from_mag(r_neg, n_acc >> FRAC_BITS);
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_num = r_num << 1;
                if (!rem_sub[W]) begin
                    n_rem = rem_sub;
                    n_q = {r_q[W2-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q = {r_q[W2-2:0], 1'b0};
                end
                n_i = r_i - IW'(1);
                if (r_i == IW'(1)) begin
                    n_res = from_mag(r_neg, n_q);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_has) begin
                    if (r_cnt == CW'(STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_we = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                n_out.printed_value   = (r_kind == K_EOL) ? 64'(r_b) : '0;
                n_out.printed_valid   = (r_kind == K_EOL);
                n_out.underflow       = r_und;
                n_out.overflow        = n_ovf;
                n_out.zero_divisor    = r_zd;
                n_out.unknown_command = (r_kind == K_UNK || r_kind == K_RSV);
                n_out.stack_depth     = 8'(n_cnt);
                n_ov = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_ov = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

/* rtl/rse_checker.sv */
// ----------------------------------------------------------------------------
// rse_checker: port-level checks for the RPN stack evaluator
// Watches the handshakes and result flags over time.
// ----------------------------------------------------------------------------
module rse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input rse_pkg::t_out o_data
);
    import rse_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // one token in flight: no accept while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("token accepted with result pending");

    // drop ready right after a token beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after token accept");

    // printed value is zero unless end of line
    a_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.printed_valid |-> o_data.printed_value == '0)
        else $error("stray printed value");

    // an unknown token never touches the stack flags
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.unknown_command |->
            !o_data.underflow && !o_data.overflow && !o_data.zero_divisor)
        else $error("unknown token raised stack flag");

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
